// ===== hdl/kpat_pkg.sv =====
// ----------------------------------------------------------------------------
// kpat_pkg: shared types and constants of the keyed pre-aggregation table
// Holds the beat payload structs, the command, kind and status codes and
// the table and queue geometry used by the front queue and the table engine.
// ----------------------------------------------------------------------------
package kpat_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [3:0] KIND_SUM = 4'd1;
  localparam logic [3:0] KIND_MIN = 4'd2;
  localparam logic [3:0] KIND_MAX = 4'd3;

  localparam logic [2:0] ST_APPENDED   = 3'd0;
  localparam logic [2:0] ST_AGGREGATED = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_DRAINED    = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  typedef struct packed {
    logic               command;
    logic [31:0]        path_key;
    logic signed [63:0] sample_value;
    logic [3:0]         aggregation_kind;
    logic [47:0]        time_stamp;
  } kpat_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        out_key;
    logic signed [63:0] out_value;
    logic [3:0]         out_kind;
    logic [47:0]        out_time;
    logic               last;
  } kpat_out_t;

  // Queued item with the classification made by the front part.
  typedef struct packed {
    kpat_in_t item;
    logic     is_drain;
    logic     folds;
  } kpat_cmd_t;

  typedef struct packed {
    logic [31:0]        key;
    logic signed [63:0] value;
    logic [3:0]         kind;
    logic [47:0]        time_v;
  } kpat_entry_t;

endpackage

// ===== hdl/keyed_preaggregation_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_preaggregation_table_unit: group-by table with sum, min and max folds
// Collects metric points per key in arrival order and drains them on command.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i, in_ready_o, in_data_i) carries add and
//   drain beats. Each add gives one result beat; a drain gives one beat per
//   stored entry in arrival order, the final one flagged by last, or one
//   drain-empty beat when the table holds nothing.
//   Inputs pass through a two-deep queue, so the sender keeps going while
//   the table engine works or the receiver stalls.
//   In the engine an add passes the idle and exec states, and the append
//   state too when a matching non-folding kind both updates the stored
//   timestamp and appends, since the single-port table memory takes one
//   write per cycle. A drain passes idle, then a read and an output state
//   per entry, the memory's registered read setting the pace; an empty
//   table gets one read and output pair. A new beat waits for idle.
//   Reset empties the table and the queue at once; no clearing pass runs.
//   When out_ready_i is held low the result stays in the output register,
//   the engine waits, and new beats fill the queue until in_ready_o falls.
// ----------------------------------------------------------------------------
module keyed_preaggregation_table_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kpat_pkg::kpat_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kpat_pkg::kpat_out_t out_data_o
);
  import kpat_pkg::*;

  logic      q_valid;
  logic      q_pop;
  kpat_cmd_t q_item;

  kpat_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  kpat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The engine only takes a beat that the queue really holds.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Results of an add and an empty drain are always single beats.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_APPENDED ||
                    out_data_o.status == ST_AGGREGATED ||
                    out_data_o.status == ST_FULL ||
                    out_data_o.status == ST_EMPTY) |-> out_data_o.last)
    else $error("single-beat result without last");

  // A new result beat is never loaded over one that was not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("pending result beat overwritten");

endmodule

// ===== hdl/kpat_front.sv =====
// ----------------------------------------------------------------------------
// kpat_front: input acceptance, classification and command queue
// Accepts input beats, tags drains and folding kinds, and holds them in a
// short queue so the table engine can stall without blocking the sender.
// ----------------------------------------------------------------------------
module kpat_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kpat_pkg::kpat_in_t  in_data_i,
  output logic                q_valid_o,
  output kpat_pkg::kpat_cmd_t q_item_o,
  input  logic                q_pop_i
);
  import kpat_pkg::*;

  kpat_cmd_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  fill_q, fill_d;
  logic               push, pop;
  kpat_cmd_t          cls;

  assign in_ready_o = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (fill_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;

  always_comb begin
    cls.item     = in_data_i;
    cls.is_drain = (in_data_i.command == CMD_DRAIN);
    cls.folds    = (in_data_i.aggregation_kind == KIND_SUM) ||
                   (in_data_i.aggregation_kind == KIND_MIN) ||
                   (in_data_i.aggregation_kind == KIND_MAX);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== hdl/kpat_back.sv =====
// ----------------------------------------------------------------------------
// kpat_back: table engine with key match, fold, append and drain
// Keys and newest marks sit in flops for a parallel match; the entry
// payloads sit in a single-port table memory with a registered read.
// Results leave through an output register.
// ----------------------------------------------------------------------------
module kpat_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  kpat_pkg::kpat_cmd_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kpat_pkg::kpat_out_t out_data_o
);
  import kpat_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_DRD    = 3'd3;
  localparam logic [2:0] S_DOUT   = 3'd4;

  logic [2:0]             state_q, state_d;
  kpat_in_t               item_q, item_d;
  logic                   folds_q, folds_d;
  logic                   hit_q, hit_d;
  logic [IDX_W-1:0]       hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]       drain_idx_q, drain_idx_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [TABLE_DEPTH-1:0] newest_q, newest_d;
  logic [31:0]            key_q [TABLE_DEPTH];

  kpat_entry_t            mem [TABLE_DEPTH];
  kpat_entry_t            rd_q;
  logic                   mem_we, mem_re, key_we;
  logic [IDX_W-1:0]       mem_waddr, mem_raddr;
  kpat_entry_t            mem_wdata;

  logic                   out_valid_q;
  kpat_out_t              out_q, out_d;
  logic                   out_load, out_free;

  logic [TABLE_DEPTH-1:0] match;
  logic                   enc_hit;
  logic [IDX_W-1:0]       enc_idx;

  logic                   kind_match, do_fold, full, drain_last;
  logic [IDX_W-1:0]       cnt_idx;
  logic [47:0]            time_max;
  logic signed [63:0]     fold_val;
  kpat_entry_t            upd_entry, new_entry;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Only newest entries carry a mark, so at most one bit of match is set.
  always_comb begin
    enc_hit = 1'b0;
    enc_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = newest_q[i] && (key_q[i] == q_item_i.item.path_key);
    end
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        enc_hit = 1'b1;
        enc_idx = IDX_W'(i);
      end
    end
  end

  assign cnt_idx    = count_q[IDX_W-1:0];
  assign full       = (count_q >= CNT_W'(TABLE_DEPTH));
  assign kind_match = hit_q && (rd_q.kind == item_q.aggregation_kind);
  assign do_fold    = kind_match && folds_q;
  assign time_max   = (item_q.time_stamp > rd_q.time_v) ? item_q.time_stamp : rd_q.time_v;
  assign drain_last = ((CNT_W'(drain_idx_q) + CNT_W'(1)) == count_q);

  always_comb begin
    case (item_q.aggregation_kind)
      KIND_SUM: fold_val = rd_q.value + item_q.sample_value;
      KIND_MIN: fold_val = ($signed(item_q.sample_value) < $signed(rd_q.value)) ?
                           item_q.sample_value : rd_q.value;
      KIND_MAX: fold_val = ($signed(rd_q.value) < $signed(item_q.sample_value)) ?
                           item_q.sample_value : rd_q.value;
      default:  fold_val = rd_q.value;
    endcase
  end

  always_comb begin
    upd_entry        = rd_q;
    upd_entry.value  = do_fold ? fold_val : rd_q.value;
    upd_entry.time_v = time_max;
    new_entry.key    = item_q.path_key;
    new_entry.value  = item_q.sample_value;
    new_entry.kind   = item_q.aggregation_kind;
    new_entry.time_v = item_q.time_stamp;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    folds_d     = folds_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    drain_idx_d = drain_idx_q;
    count_d     = count_q;
    newest_d    = newest_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_q;
    mem_wdata   = upd_entry;
    mem_re      = 1'b0;
    mem_raddr   = enc_idx;
    key_we      = 1'b0;
    out_load    = 1'b0;
    out_d       = out_q;

    unique case (state_q) inside
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i.item;
          folds_d = q_item_i.folds;
          if (q_item_i.is_drain) begin
            drain_idx_d = '0;
            state_d     = S_DRD;
          end else begin
            mem_re    = 1'b1;
            hit_d     = enc_hit;
            hit_idx_d = enc_idx;
            state_d   = S_EXEC;
          end
        end
      end

      S_EXEC, S_APPEND: begin
        if (out_free) begin
          if (state_q == S_EXEC && (do_fold || full || kind_match)) begin
            // Timestamp (and folded value) go back to the matching entry.
            if (kind_match) begin
              mem_we = 1'b1;
            end
            if (do_fold) begin
              out_load        = 1'b1;
              out_d.status    = ST_AGGREGATED;
              out_d.out_key   = item_q.path_key;
              out_d.out_value = upd_entry.value;
              out_d.out_kind  = rd_q.kind;
              out_d.out_time  = time_max;
              out_d.last      = 1'b1;
              state_d         = S_IDLE;
            end else if (full) begin
              out_load        = 1'b1;
              out_d.status    = ST_FULL;
              out_d.out_key   = item_q.path_key;
              out_d.out_value = item_q.sample_value;
              out_d.out_kind  = item_q.aggregation_kind;
              out_d.out_time  = item_q.time_stamp;
              out_d.last      = 1'b1;
              state_d         = S_IDLE;
            end else begin
              state_d = S_APPEND;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cnt_idx;
            mem_wdata = new_entry;
            key_we    = 1'b1;
            if (hit_q) begin
              newest_d[hit_idx_q] = 1'b0;
            end
            newest_d[cnt_idx] = 1'b1;
            count_d           = count_q + CNT_W'(1);
            out_load          = 1'b1;
            out_d.status      = ST_APPENDED;
            out_d.out_key     = item_q.path_key;
            out_d.out_value   = item_q.sample_value;
            out_d.out_kind    = item_q.aggregation_kind;
            out_d.out_time    = item_q.time_stamp;
            out_d.last        = 1'b1;
            state_d           = S_IDLE;
          end
        end
      end

      S_DRD: begin
        mem_re    = 1'b1;
        mem_raddr = drain_idx_q;
        state_d   = S_DOUT;
      end

      S_DOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (count_q == '0) begin
            out_d.status    = ST_EMPTY;
            out_d.out_key   = '0;
            out_d.out_value = '0;
            out_d.out_kind  = '0;
            out_d.out_time  = '0;
            out_d.last      = 1'b1;
            state_d         = S_IDLE;
          end else begin
            out_d.status    = ST_DRAINED;
            out_d.out_key   = rd_q.key;
            out_d.out_value = rd_q.value;
            out_d.out_kind  = rd_q.kind;
            out_d.out_time  = rd_q.time_v;
            out_d.last      = drain_last;
            if (drain_last) begin
              newest_d = '0;
              count_d  = '0;
              state_d  = S_IDLE;
            end else begin
              drain_idx_d = drain_idx_q + IDX_W'(1);
              state_d     = S_DRD;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      newest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      newest_q <= newest_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    folds_q     <= folds_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    drain_idx_q <= drain_idx_d;
    if (out_load) begin
      out_q <= out_d;
    end
    if (key_we) begin
      key_q[cnt_idx] <= item_q.path_key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keyed_preaggregation_table_unit
// Walks a short table of directed beats, then random episodes of add beats
// over small key pools, each closed by a drain. A behavioral copy of the
// table predicts every result beat a row does not give; the bench compares
// them field by field. Both channels idle at random. The receiver holds off
// once for a long stretch, and the sender pauses until the table has answered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kpat_pkg::*;

  localparam int          RANDOM_BEATS = 260;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          TAIL_CYCLES  = 80;
  localparam logic [3:0]  KIND_NONE    = 4'd0;
  localparam logic [3:0]  KIND_AVG     = 4'd4;
  localparam logic [3:0]  KIND_P99     = 4'd9;
  localparam logic [3:0]  KIND_INVALID = 4'd10;
  localparam logic [3:0]  KIND_TOP     = 4'd15;
  localparam logic [63:0] VAL_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] KEY_MAX      = 32'hFFFF_FFFF;

  typedef struct packed {
    kpat_in_t  beat;
    logic      typed;
    kpat_out_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  kpat_in_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  kpat_out_t out_data_o;

  // Behavioral copy of the table.
  kpat_entry_t            agg_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] agg_newest = '0;
  int                     agg_count  = 0;

  kpat_out_t pending_results [$];
  kpat_out_t beat_results [$];
  dir_row_t  dir_rows [$];
  kpat_out_t want_r;

  int errors       = 0;
  int results_seen = 0;
  int beats_sent   = 0;
  int cycles       = 0;

  keyed_preaggregation_table_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Applies one accepted beat to the table copy and leaves its results in
  // beat_results.
  function automatic void fold_beat(input kpat_in_t b);
    int        hit;
    int        i;
    kpat_out_t r;
    beat_results.delete();
    r      = '0;
    r.last = 1'b1;
    if (b.command == CMD_DRAIN) begin
      if (agg_count == 0) begin
        r.status = ST_EMPTY;
        beat_results.insert(beat_results.size(), r);
      end else begin
        for (i = 0; i < agg_count; i++) begin
          r.status    = ST_DRAINED;
          r.out_key   = agg_entry[i].key;
          r.out_value = agg_entry[i].value;
          r.out_kind  = agg_entry[i].kind;
          r.out_time  = agg_entry[i].time_v;
          r.last      = (i == agg_count - 1);
          beat_results.insert(beat_results.size(), r);
        end
        agg_newest = '0;
        agg_count  = 0;
      end
      return;
    end
    hit = -1;
    for (i = 0; i < agg_count; i++) begin
      if (hit < 0 && agg_newest[i] && agg_entry[i].key == b.path_key) hit = i;
    end
    if (hit >= 0 && agg_entry[hit].kind == b.aggregation_kind) begin
      if (b.time_stamp > agg_entry[hit].time_v) agg_entry[hit].time_v = b.time_stamp;
      if (b.aggregation_kind == KIND_SUM || b.aggregation_kind == KIND_MIN ||
          b.aggregation_kind == KIND_MAX) begin
        if (b.aggregation_kind == KIND_SUM) begin
          agg_entry[hit].value = agg_entry[hit].value + b.sample_value;
        end else if (b.aggregation_kind == KIND_MIN) begin
          if ($signed(b.sample_value) < $signed(agg_entry[hit].value))
            agg_entry[hit].value = b.sample_value;
        end else begin
          if ($signed(agg_entry[hit].value) < $signed(b.sample_value))
            agg_entry[hit].value = b.sample_value;
        end
        r.status    = ST_AGGREGATED;
        r.out_key   = b.path_key;
        r.out_value = agg_entry[hit].value;
        r.out_kind  = agg_entry[hit].kind;
        r.out_time  = agg_entry[hit].time_v;
        beat_results.insert(beat_results.size(), r);
        return;
      end
    end
    // A dropped point and an appended one both echo the input point.
    r.out_key   = b.path_key;
    r.out_value = b.sample_value;
    r.out_kind  = b.aggregation_kind;
    r.out_time  = b.time_stamp;
    if (agg_count >= TABLE_DEPTH) begin
      r.status = ST_FULL;
    end else begin
      if (hit >= 0) agg_newest[hit] = 1'b0;
      agg_entry[agg_count].key    = b.path_key;
      agg_entry[agg_count].value  = b.sample_value;
      agg_entry[agg_count].kind   = b.aggregation_kind;
      agg_entry[agg_count].time_v = b.time_stamp;
      agg_newest[agg_count]       = 1'b1;
      agg_count++;
      r.status = ST_APPENDED;
    end
    beat_results.insert(beat_results.size(), r);
  endfunction

  function automatic kpat_in_t add_point(input logic [31:0] key, input logic [63:0] val,
                                         input logic [3:0] kind, input logic [47:0] tm);
    kpat_in_t b;
    b.command          = CMD_ADD;
    b.path_key         = key;
    b.sample_value     = val;
    b.aggregation_kind = kind;
    b.time_stamp       = tm;
    return b;
  endfunction

  function automatic kpat_out_t single_result(input logic [2:0] st, input logic [31:0] key,
                                              input logic [63:0] val, input logic [3:0] kind,
                                              input logic [47:0] tm);
    kpat_out_t r;
    r.status    = st;
    r.out_key   = key;
    r.out_value = val;
    r.out_kind  = kind;
    r.out_time  = tm;
    r.last      = 1'b1;
    return r;
  endfunction

  function automatic void push_row(input kpat_in_t b, input logic typed, input kpat_out_t want);
    dir_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return 64'($signed($urandom_range(16)) - 8);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [47:0] rand_time();
    case ($urandom_range(5))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return 48'($urandom_range(1000));
      default: return {16'($urandom), $urandom};
    endcase
  endfunction

  // Offers one beat, waits for the handshake and records what it should give.
  task automatic send_beat(input kpat_in_t b, input logic typed, input kpat_out_t want);
    if (!(beats_sent >= 120 && beats_sent < 180)) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(negedge clk); while (in_ready_o !== 1'b1);
    @(posedge clk);
    beats_sent++;
    fold_beat(b);
    if (typed) begin
      pending_results.insert(pending_results.size(), want);
    end else begin
      foreach (beat_results[k]) pending_results.insert(pending_results.size(), beat_results[k]);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int          ep;
    int          j;
    int          len;
    int          n_keys;
    int          random_sent;
    logic        fill_mode;
    logic [31:0] key_pool [8];
    kpat_in_t    b;

    push_row({CMD_DRAIN, KEY_MAX, 64'hFFFF_FFFF_FFFF_FFFF, KIND_TOP, TIME_MAX}, 1'b1,
             single_result(ST_EMPTY, '0, '0, '0, '0));
    push_row(add_point('0, VAL_MIN, KIND_SUM, '0), 1'b1,
             single_result(ST_APPENDED, '0, VAL_MIN, KIND_SUM, '0));
    // The sum wraps in both directions.
    push_row(add_point('0, '1, KIND_SUM, TIME_MAX), 1'b1,
             single_result(ST_AGGREGATED, '0, VAL_MAX, KIND_SUM, TIME_MAX));
    push_row(add_point('0, 64'd1, KIND_SUM, 48'd5), 1'b1,
             single_result(ST_AGGREGATED, '0, VAL_MIN, KIND_SUM, TIME_MAX));
    push_row(add_point(KEY_MAX, VAL_MAX, KIND_MIN, TIME_MAX), 1'b1,
             single_result(ST_APPENDED, KEY_MAX, VAL_MAX, KIND_MIN, TIME_MAX));
    push_row(add_point(KEY_MAX, VAL_MIN, KIND_MIN, '0), 1'b1,
             single_result(ST_AGGREGATED, KEY_MAX, VAL_MIN, KIND_MIN, TIME_MAX));
    push_row(add_point(KEY_MAX, '0, KIND_MIN, 48'd1), 1'b0, '0);
    push_row(add_point(32'd1, VAL_MIN, KIND_MAX, 48'd10), 1'b1,
             single_result(ST_APPENDED, 32'd1, VAL_MIN, KIND_MAX, 48'd10));
    push_row(add_point(32'd1, VAL_MAX, KIND_MAX, 48'd3), 1'b1,
             single_result(ST_AGGREGATED, 32'd1, VAL_MAX, KIND_MAX, 48'd10));
    // A kind mismatch appends, and the new entry then shadows the old one.
    push_row(add_point(32'd1, 64'd3, KIND_MIN, 48'd20), 1'b0, '0);
    push_row(add_point(32'd1, 64'd7, KIND_MAX, 48'd30), 1'b0, '0);
    push_row(add_point(32'd2, 64'd100, KIND_NONE, 48'd100), 1'b0, '0);
    push_row(add_point(32'd2, 64'd200, KIND_NONE, 48'd200), 1'b0, '0);
    push_row(add_point(32'd2, -64'sd5, KIND_AVG, 48'd50), 1'b0, '0);
    push_row(add_point(32'd3, 64'd9, KIND_INVALID, TIME_MAX), 1'b0, '0);
    push_row(add_point(32'd3, 64'd9, KIND_P99, '0), 1'b0, '0);
    push_row(add_point(32'd3, 64'd11, KIND_TOP, 48'd7), 1'b0, '0);
    push_row(add_point(32'd3, 64'd12, KIND_TOP, 48'd6), 1'b0, '0);
    push_row({CMD_DRAIN, 32'd0, 64'd0, KIND_NONE, 48'd0}, 1'b0, '0);
    push_row({CMD_DRAIN, 32'd0, 64'd0, KIND_NONE, 48'd0}, 1'b1,
             single_result(ST_EMPTY, '0, '0, '0, '0));
    push_row(add_point(32'd5, '0, KIND_SUM, '0), 1'b1,
             single_result(ST_APPENDED, 32'd5, '0, KIND_SUM, '0));
    push_row({CMD_DRAIN, 32'h1234_5678, VAL_MAX, KIND_MIN, 48'd1}, 1'b1,
             single_result(ST_DRAINED, 32'd5, '0, KIND_SUM, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);

    random_sent = 0;
    ep          = 0;
    while (random_sent < RANDOM_BEATS) begin
      // The first episode runs the table past full after a quiet start.
      fill_mode = (ep == 0) || ($urandom_range(99) < 12);
      if (ep == 0) wait_for_results();
      n_keys = $urandom_range(8, 1);
      for (j = 0; j < 8; j++) begin
        case ($urandom_range(9))
          0:       key_pool[j] = '0;
          1:       key_pool[j] = KEY_MAX;
          default: key_pool[j] = $urandom;
        endcase
      end
      len = fill_mode ? $urandom_range(44, 34) : $urandom_range(24, 1);
      for (j = 0; j < len; j++) begin
        b = add_point(key_pool[$urandom_range(n_keys - 1)], rand_value(), KIND_NONE,
                      rand_time());
        if (fill_mode ? ($urandom_range(99) < 80) : ($urandom_range(99) < 25))
          b.aggregation_kind = 4'($urandom_range(15));
        else
          b.aggregation_kind = 4'($urandom_range(KIND_MAX, KIND_SUM));
        // The random pick of kind may land on 1..3 too; broken sequences
        // come from stray drains in the middle of an episode.
        if (!fill_mode && $urandom_range(99) < 4) b.command = CMD_DRAIN;
        send_beat(b, 1'b0, '0);
        random_sent++;
      end
      b.command          = CMD_DRAIN;
      b.path_key         = $urandom;
      b.sample_value     = rand_value();
      b.aggregation_kind = 4'($urandom_range(15));
      b.time_stamp       = rand_time();
      send_beat(b, 1'b0, '0);
      random_sent++;
      if ($urandom_range(99) < 10) begin
        send_beat(b, 1'b0, '0);
        random_sent++;
      end
      ep++;
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    int   k;
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 100) begin
        // Long hold-off so the queue fills and the input stalls.
        held = 1'b1;
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else if (results_seen >= 150 && results_seen < 250) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic void note_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Outputs are sampled at the falling edge; a beat seen here is taken at the
  // next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid_o === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        want_r = pending_results.pop_front();
        note_field("status", 64'(want_r.status), 64'(out_data_o.status));
        note_field("out_key", 64'(want_r.out_key), 64'(out_data_o.out_key));
        note_field("out_value", want_r.out_value, out_data_o.out_value);
        note_field("out_kind", 64'(want_r.out_kind), 64'(out_data_o.out_kind));
        note_field("out_time", 64'(want_r.out_time), 64'(out_data_o.out_time));
        note_field("last", 64'(want_r.last), 64'(out_data_o.last));
      end
    end
  end

endmodule

// ===== files.f =====
hdl/kpat_pkg.sv
hdl/kpat_front.sv
hdl/kpat_back.sv
hdl/keyed_preaggregation_table_unit.sv
tb/testbench.sv
